// ===== rtl/kf3_pkg.sv =====
// kf3_pkg: shared types, register indexes, sequencer op codes and helpers
// for the three-axis two-sensor kalman fusion block; depends on nothing
`default_nettype none
package kf3_pkg;

   localparam int AXES   = 3;
   localparam int AXIS_W = 2;
   localparam int DIV_W  = 48;

   typedef logic signed [31:0] q_type;

   // configuration register indexes
   localparam logic [2:0] CSR_INITIAL_VARIANCE = 3'd0;
   localparam logic [2:0] CSR_TRANSITION_GAIN  = 3'd1;
   localparam logic [2:0] CSR_PROCESS_NOISE    = 3'd2;
   localparam logic [2:0] CSR_FIRST_OBS_GAIN   = 3'd3;
   localparam logic [2:0] CSR_FIRST_NOISE      = 3'd4;
   localparam logic [2:0] CSR_SECOND_OBS_GAIN  = 3'd5;
   localparam logic [2:0] CSR_SECOND_NOISE     = 3'd6;

   // operand selects
   localparam logic [3:0] SEL_F   = 4'd0;
   localparam logic [3:0] SEL_E   = 4'd1;
   localparam logic [3:0] SEL_P   = 4'd2;
   localparam logic [3:0] SEL_T   = 4'd3;
   localparam logic [3:0] SEL_H   = 4'd4;
   localparam logic [3:0] SEL_K   = 4'd5;
   localparam logic [3:0] SEL_Z   = 4'd6;
   localparam logic [3:0] SEL_R   = 4'd7;
   localparam logic [3:0] SEL_Q   = 4'd8;
   localparam logic [3:0] SEL_ONE = 4'd9;

   // post operations after the rounded product
   localparam logic [1:0] POST_NONE = 2'd0;
   localparam logic [1:0] POST_ADD  = 2'd1;
   localparam logic [1:0] POST_RSUB = 2'd2;

   // destinations
   localparam logic [2:0] DST_E   = 3'd0;
   localparam logic [2:0] DST_P   = 3'd1;
   localparam logic [2:0] DST_T   = 3'd2;
   localparam logic [2:0] DST_NUM = 3'd3;
   localparam logic [2:0] DST_DEN = 3'd4;

   localparam logic [3:0] OP_LAST = 4'd10;

   localparam logic signed [31:0] Q_ONE = 32'sd65536;
   localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] Q_MIN = 32'sh80000000;

   typedef struct packed {
      logic       is_div;
      logic [3:0] a_sel;
      logic [3:0] b_sel;
      logic [3:0] c_sel;
      logic [1:0] post;
      logic [2:0] dst;
   } op_type;

   typedef struct packed {
      logic              capture;
      logic              mul_go;
      logic              wb;
      logic              div_init;
      logic              div_step;
      logic              div_wb;
      logic              out_load;
      logic              sens;
      logic [AXIS_W-1:0] axis;
      op_type            op;
   } cmd_type;

   // one predict (ops 0..2) then one update (ops 3..10)
   function automatic op_type op_decode(logic [3:0] idx);
      op_type o;
      o = '0;
      case (idx)
         4'd0: begin
            o.a_sel = SEL_F; o.b_sel = SEL_E; o.dst = DST_E;
         end
         4'd1: begin
            o.a_sel = SEL_F; o.b_sel = SEL_P; o.dst = DST_T;
         end
         4'd2: begin
            o.a_sel = SEL_T; o.b_sel = SEL_F; o.c_sel = SEL_Q;
            o.post = POST_ADD; o.dst = DST_P;
         end
         4'd3: begin
            o.a_sel = SEL_P; o.b_sel = SEL_H; o.dst = DST_NUM;
         end
         4'd4: begin
            o.a_sel = SEL_H; o.b_sel = SEL_P; o.dst = DST_T;
         end
         4'd5: begin
            o.a_sel = SEL_T; o.b_sel = SEL_H; o.c_sel = SEL_R;
            o.post = POST_ADD; o.dst = DST_DEN;
         end
         4'd6: begin
            o.is_div = 1'b1;
         end
         4'd7: begin
            o.a_sel = SEL_H; o.b_sel = SEL_E; o.c_sel = SEL_Z;
            o.post = POST_RSUB; o.dst = DST_T;
         end
         4'd8: begin
            o.a_sel = SEL_K; o.b_sel = SEL_T; o.c_sel = SEL_E;
            o.post = POST_ADD; o.dst = DST_E;
         end
         4'd9: begin
            o.a_sel = SEL_K; o.b_sel = SEL_H; o.c_sel = SEL_ONE;
            o.post = POST_RSUB; o.dst = DST_T;
         end
         4'd10: begin
            o.a_sel = SEL_T; o.b_sel = SEL_P; o.dst = DST_P;
         end
         default: begin
            o = '0;
         end
      endcase
      return o;
   endfunction

   function automatic q_type sat64(logic signed [63:0] v);
      q_type r;
      if (v > 64'sh000000007fffffff) r = Q_MAX;
      else if (v < -64'sh0000000080000000) r = Q_MIN;
      else r = v[31:0];
      return r;
   endfunction

   function automatic q_type sat33(logic signed [32:0] v);
      q_type r;
      if (v > 33'sh07fffffff) r = Q_MAX;
      else if (v < -33'sh080000000) r = Q_MIN;
      else r = v[31:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/kf3_req_if.sv =====
// kf3_req_if: input channel, two sensor readings per axis and a restart flag
// depends on nothing
`default_nettype none
interface kf3_req_if;
   logic        valid;
   logic        ready;
   logic        restart;
   logic [31:0] first_x;
   logic [31:0] first_y;
   logic [31:0] first_z;
   logic [31:0] second_x;
   logic [31:0] second_y;
   logic [31:0] second_z;

   modport source (output valid, restart, first_x, first_y, first_z,
                   second_x, second_y, second_z, input ready);
   modport sink (input valid, restart, first_x, first_y, first_z,
                 second_x, second_y, second_z, output ready);
endinterface
`default_nettype wire

// ===== rtl/kf3_rsp_if.sv =====
// kf3_rsp_if: result channel, fused estimate per axis
// depends on nothing
`default_nettype none
interface kf3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] estimate_x;
   logic [31:0] estimate_y;
   logic [31:0] estimate_z;

   modport source (output valid, estimate_x, estimate_y, estimate_z, input ready);
   modport sink (input valid, estimate_x, estimate_y, estimate_z, output ready);
endinterface
`default_nettype wire

// ===== rtl/two_sensor_kalman_fusion_3axis.sv =====
// Three-axis scalar Kalman fusion of two position sensors in signed Q16.16.
// Each word on req_chan carries one reading per axis from both sensors. Per
// axis the block predicts, updates with sensor one, then predicts and updates
// with sensor two. Estimate and variance per axis are kept across words;
// restart reloads zero estimates and initial_variance first. A new word is
// taken only in idle, once the result of the last word is loaded. Per axis
// and sensor there are 10 products (3 predict, 7 update) on the shared 32x32
// multiplier, each a multiply and a write-back, plus a gain divide (a start
// step, 48 one-bit-a-cycle steps and a write-back). A last state loads the
// result. A new word is taken while a result still waits on rsp_chan. The next
// result is held back until the waiting one is taken. Configuration is to be
// written on csr_ by the user while idle; the block itself does not enforce it.
`default_nettype none
module two_sensor_kalman_fusion_3axis (
   input  wire          clock,
   input  wire          reset,
   input  wire          csr_write_enable,
   input  wire  [2:0]   csr_index,
   input  wire  [31:0]  csr_write_data,
   kf3_req_if.sink      req_chan,
   kf3_rsp_if.source    rsp_chan
);

   kf3_pkg::cmd_type cmd;

   // sequencer
   kf3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // arithmetic and state
   kf3_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .restart          (req_chan.restart),
      .first_x          (req_chan.first_x),
      .first_y          (req_chan.first_y),
      .first_z          (req_chan.first_z),
      .second_x         (req_chan.second_x),
      .second_y         (req_chan.second_y),
      .second_z         (req_chan.second_z),
      .cmd              (cmd),
      .estimate_x       (rsp_chan.estimate_x),
      .estimate_y       (rsp_chan.estimate_y),
      .estimate_z       (rsp_chan.estimate_z)
   );

endmodule
`default_nettype wire

// ===== rtl/kf3_ctrl.sv =====
// kf3_ctrl: sequencer walking axes, sensors and micro ops, and the result valid
// depends on kf3_pkg
`default_nettype none
module kf3_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output kf3_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_WB    = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_DIVWB = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   localparam logic [5:0] DIV_LAST = 6'(kf3_pkg::DIV_W - 1);
   localparam logic [kf3_pkg::AXIS_W-1:0] AXIS_LAST = kf3_pkg::AXIS_W'(kf3_pkg::AXES - 1);

   logic [2:0]                   state_ff, state_in;
   logic [3:0]                   op_ff, op_in;
   logic                         sens_ff, sens_in;
   logic [kf3_pkg::AXIS_W-1:0]   axis_ff, axis_in;
   logic [5:0]                   cnt_ff, cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   kf3_pkg::op_type              op_dec;
   logic                         adv;

   assign op_dec    = kf3_pkg::op_decode(op_ff);
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      sens_in      = sens_ff;
      axis_in      = axis_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      adv          = 1'b0;
      cmd          = '0;
      cmd.sens     = sens_ff;
      cmd.axis     = axis_ff;
      cmd.op       = op_dec;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               op_in       = '0;
               sens_in     = 1'b0;
               axis_in     = '0;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            if (op_dec.is_div) begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = S_DIV;
            end else begin
               cmd.mul_go = 1'b1;
               state_in   = S_WB;
            end
         end
         S_WB: begin
            cmd.wb = 1'b1;
            adv    = 1'b1;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) state_in = S_DIVWB;
         end
         S_DIVWB: begin
            cmd.div_wb = 1'b1;
            adv        = 1'b1;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // step to next op, sensor, axis
      if (adv) begin
         state_in = S_MUL;
         if (op_ff == kf3_pkg::OP_LAST) begin
            op_in = '0;
            if (sens_ff) begin
               sens_in = 1'b0;
               if (axis_ff == AXIS_LAST) state_in = S_OUT;
               else axis_in = axis_ff + 1'b1;
            end else begin
               sens_in = 1'b1;
            end
         end else begin
            op_in = op_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= '0;
         sens_ff      <= 1'b0;
         axis_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         sens_ff      <= sens_in;
         axis_ff      <= axis_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/kf3_dp.sv =====
// kf3_dp: configuration registers, per-axis state, shared q16.16 multiplier,
// bit-serial divider and result register; depends on kf3_pkg
`default_nettype none
module kf3_dp (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 csr_write_enable,
   input  wire  [2:0]          csr_index,
   input  wire  [31:0]         csr_write_data,
   input  wire                 restart,
   input  wire  [31:0]         first_x,
   input  wire  [31:0]         first_y,
   input  wire  [31:0]         first_z,
   input  wire  [31:0]         second_x,
   input  wire  [31:0]         second_y,
   input  wire  [31:0]         second_z,
   input  kf3_pkg::cmd_type    cmd,
   output logic [31:0]         estimate_x,
   output logic [31:0]         estimate_y,
   output logic [31:0]         estimate_z
);

   localparam int AX = kf3_pkg::AXES;
   localparam int DW = kf3_pkg::DIV_W;

   logic [30:0]     init_var_ff, proc_noise_ff, noise1_ff, noise2_ff;
   kf3_pkg::q_type  trans_ff, gain1_ff, gain2_ff;
   kf3_pkg::q_type  z1_ff [AX];
   kf3_pkg::q_type  z2_ff [AX];
   kf3_pkg::q_type  est_ff [AX];
   kf3_pkg::q_type  var_ff [AX];
   kf3_pkg::q_type  out_ff [AX];
   kf3_pkg::q_type  t_ff, k_ff, num_ff, den_ff;
   logic signed [63:0] prod_ff;
   logic [30:0]     rem_ff;
   logic [DW-1:0]   quo_ff;
   logic            neg_ff;

   kf3_pkg::q_type  a_val, b_val, c_val, m_val, wb_val;
   kf3_pkg::q_type  h_val, z_val;
   logic [30:0]     r_val;
   logic signed [63:0] rnd;
   logic [31:0]     rem_sh, num_mag;
   logic            ge;
   kf3_pkg::q_type  k_val;

   assign h_val = cmd.sens ? gain2_ff : gain1_ff;
   assign r_val = cmd.sens ? noise2_ff : noise1_ff;
   assign z_val = cmd.sens ? z2_ff[cmd.axis] : z1_ff[cmd.axis];

   function automatic kf3_pkg::q_type pick(logic [3:0] sel);
      kf3_pkg::q_type v;
      case (sel)
         kf3_pkg::SEL_F:   v = trans_ff;
         kf3_pkg::SEL_E:   v = est_ff[cmd.axis];
         kf3_pkg::SEL_P:   v = var_ff[cmd.axis];
         kf3_pkg::SEL_T:   v = t_ff;
         kf3_pkg::SEL_H:   v = h_val;
         kf3_pkg::SEL_K:   v = k_ff;
         kf3_pkg::SEL_Z:   v = z_val;
         kf3_pkg::SEL_R:   v = {1'b0, r_val};
         kf3_pkg::SEL_Q:   v = {1'b0, proc_noise_ff};
         kf3_pkg::SEL_ONE: v = kf3_pkg::Q_ONE;
         default:          v = '0;
      endcase
      return v;
   endfunction

   // operand select, rounding, post add or subtract
   always_comb begin
      a_val = pick(cmd.op.a_sel);
      b_val = pick(cmd.op.b_sel);
      c_val = pick(cmd.op.c_sel);
      rnd   = (prod_ff + 64'sd32768) >>> 16;
      m_val = kf3_pkg::sat64(rnd);
      case (cmd.op.post)
         kf3_pkg::POST_ADD:  wb_val = kf3_pkg::sat33(33'(c_val) + 33'(m_val));
         kf3_pkg::POST_RSUB: wb_val = kf3_pkg::sat33(33'(c_val) - 33'(m_val));
         default:            wb_val = m_val;
      endcase
   end

   // divider step and final gain with sign and saturation
   always_comb begin
      num_mag = num_ff[31] ? (~num_ff + 32'd1) : num_ff;
      rem_sh  = {rem_ff, quo_ff[DW-1]};
      ge      = (rem_sh >= {1'b0, den_ff[30:0]});
      if (den_ff <= 0) begin
         k_val = '0;
      end else if (!neg_ff) begin
         k_val = (quo_ff > DW'(32'h7fffffff)) ? kf3_pkg::Q_MAX : quo_ff[31:0];
      end else begin
         k_val = (quo_ff > DW'(32'h80000000)) ? kf3_pkg::Q_MIN : (~quo_ff[31:0] + 32'd1);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         init_var_ff   <= 31'd65536000;
         trans_ff      <= 32'sd65536;
         proc_noise_ff <= 31'd66;
         gain1_ff      <= 32'sd65536;
         noise1_ff     <= 31'd65536;
         gain2_ff      <= 32'sd65536;
         noise2_ff     <= 31'd163840;
      end else if (csr_write_enable) begin
         case (csr_index)
            kf3_pkg::CSR_INITIAL_VARIANCE: init_var_ff   <= csr_write_data[30:0];
            kf3_pkg::CSR_TRANSITION_GAIN:  trans_ff      <= csr_write_data;
            kf3_pkg::CSR_PROCESS_NOISE:    proc_noise_ff <= csr_write_data[30:0];
            kf3_pkg::CSR_FIRST_OBS_GAIN:   gain1_ff      <= csr_write_data;
            kf3_pkg::CSR_FIRST_NOISE:      noise1_ff     <= csr_write_data[30:0];
            kf3_pkg::CSR_SECOND_OBS_GAIN:  gain2_ff      <= csr_write_data;
            kf3_pkg::CSR_SECOND_NOISE:     noise2_ff     <= csr_write_data[30:0];
            default: begin
            end
         endcase
      end
   end

   // per-axis estimate and variance
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AX; i++) begin
            est_ff[i] <= '0;
            var_ff[i] <= 32'sd65536000;
         end
      end else if (cmd.capture && restart) begin
         for (int i = 0; i < AX; i++) begin
            est_ff[i] <= '0;
            var_ff[i] <= {1'b0, init_var_ff};
         end
      end else if (cmd.wb) begin
         if (cmd.op.dst == kf3_pkg::DST_E) est_ff[cmd.axis] <= wb_val;
         if (cmd.op.dst == kf3_pkg::DST_P) var_ff[cmd.axis] <= wb_val;
      end
   end

   // measurement capture, scratch, multiplier, divider, result
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         z1_ff[0] <= first_x;
         z1_ff[1] <= first_y;
         z1_ff[2] <= first_z;
         z2_ff[0] <= second_x;
         z2_ff[1] <= second_y;
         z2_ff[2] <= second_z;
      end
      if (cmd.mul_go) prod_ff <= 64'(a_val) * 64'(b_val);
      if (cmd.wb) begin
         if (cmd.op.dst == kf3_pkg::DST_T)   t_ff   <= wb_val;
         if (cmd.op.dst == kf3_pkg::DST_NUM) num_ff <= wb_val;
         if (cmd.op.dst == kf3_pkg::DST_DEN) den_ff <= wb_val;
      end
      if (cmd.div_init) begin
         neg_ff <= num_ff[31];
         rem_ff <= '0;
         quo_ff <= {num_mag, 16'd0};
      end else if (cmd.div_step) begin
         rem_ff <= ge ? 31'(rem_sh - {1'b0, den_ff[30:0]}) : rem_sh[30:0];
         quo_ff <= {quo_ff[DW-2:0], ge};
      end
      if (cmd.div_wb) k_ff <= k_val;
      if (cmd.out_load) begin
         for (int i = 0; i < AX; i++) out_ff[i] <= est_ff[i];
      end
   end

   assign estimate_x = out_ff[0];
   assign estimate_y = out_ff[1];
   assign estimate_z = out_ff[2];

endmodule
`default_nettype wire
